@@ sv/ocvm_pkg.sv @@
// ocvm_pkg: shared types, codes and fixed-point constants of the orbit camera view matrix unit
// no dependencies; imported by ocvm_ctrl, ocvm_dpath and the top level
`default_nettype none

package ocvm_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_TARGET_X = 2'd0;
    localparam logic [1:0] REG_TARGET_Y = 2'd1;
    localparam logic [1:0] REG_TARGET_Z = 2'd2;

    // matrix rows
    localparam logic [1:0] ROW_SIDE = 2'd0;
    localparam logic [1:0] ROW_UP   = 2'd1;
    localparam logic [1:0] ROW_BACK = 2'd2;
    localparam logic [1:0] ROW_HOM  = 2'd3;

    // product schedule of the shared multiplier
    localparam logic [4:0] MUL_RCP = 5'd0;
    localparam logic [4:0] MUL_EX  = 5'd1;
    localparam logic [4:0] MUL_EY  = 5'd2;
    localparam logic [4:0] MUL_EZ  = 5'd3;
    localparam logic [4:0] MUL_M10 = 5'd4;
    localparam logic [4:0] MUL_M12 = 5'd5;
    localparam logic [4:0] MUL_M20 = 5'd6;
    localparam logic [4:0] MUL_M22 = 5'd7;
    localparam logic [4:0] MUL_D0A = 5'd8;
    localparam logic [4:0] MUL_D0B = 5'd9;
    localparam logic [4:0] MUL_D0C = 5'd10;
    localparam logic [4:0] MUL_D1A = 5'd11;
    localparam logic [4:0] MUL_D1B = 5'd12;
    localparam logic [4:0] MUL_D1C = 5'd13;
    localparam logic [4:0] MUL_D2A = 5'd14;
    localparam logic [4:0] MUL_D2B = 5'd15;
    localparam logic [4:0] MUL_D2C = 5'd16;
    localparam logic [4:0] MUL_LAST = MUL_D2C;

    // angle constants
    localparam logic signed [35:0] PI_Q28       = 36'sd843314857;
    localparam logic signed [35:0] TWO_PI_Q28   = 36'sd1686629713;
    localparam logic signed [35:0] PITCH_MAX_Q28 = 36'sd421439816;
    localparam logic signed [31:0] PITCH_RESET_Q28 = 32'sd53687091;
    localparam logic signed [33:0] HALF_PI_Q30  = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30       = 34'sd3373259426;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [41:0] SENS_Q32     = 42'sd21474836;

    typedef struct packed {
        logic       capture;
        logic       update;
        logic       wrap_step;
        logic       yaw_commit;
        logic       cor_load;
        logic       cor_sel;
        logic       cor_step;
        logic [4:0] cor_iter;
        logic       cor_store;
        logic       mul_issue;
        logic       mul_wb;
        logic [4:0] mul_idx;
        logic       out_load;
        logic [1:0] out_row;
    } cmd_t;

    typedef struct packed {
        logic yaw_in_range;
        logic out_free;
    } status_t;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] a;
        case (i)
            5'd0: a = 34'sd843314856;
            5'd1: a = 34'sd497837829;
            5'd2: a = 34'sd263043836;
            5'd3: a = 34'sd133525158;
            5'd4: a = 34'sd67021686;
            5'd5: a = 34'sd33543515;
            5'd6: a = 34'sd16775850;
            5'd7: a = 34'sd8388437;
            5'd8: a = 34'sd4194282;
            5'd9: a = 34'sd2097149;
            5'd10: a = 34'sd1048575;
            5'd11: a = 34'sd524287;
            5'd12: a = 34'sd262143;
            5'd13: a = 34'sd131071;
            5'd14: a = 34'sd65535;
            5'd15: a = 34'sd32767;
            5'd16: a = 34'sd16383;
            5'd17: a = 34'sd8191;
            5'd18: a = 34'sd4095;
            5'd19: a = 34'sd2047;
            5'd20: a = 34'sd1023;
            5'd21: a = 34'sd511;
            5'd22: a = 34'sd255;
            5'd23: a = 34'sd127;
            5'd24: a = 34'sd63;
            5'd25: a = 34'sd31;
            5'd26: a = 34'sd15;
            5'd27: a = 34'sd8;
            5'd28: a = 34'sd4;
            5'd29: a = 34'sd2;
            5'd30: a = 34'sd1;
            default: a = 34'sd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

@@ sv/orbit_camera_view_matrix_unit.sv @@
// orbit_camera_view_matrix_unit: top level, joins ocvm_ctrl and ocvm_dpath
// depends on ocvm_pkg, ocvm_ctrl, ocvm_dpath
//
//  channel  handshake            payload
//  s_       s_valid / s_ready    s_move_dx, s_move_dy, s_scroll_step
//  m_       m_valid / m_ready    m_row_index, m_col0..m_col3, m_last_row
//  cfg_     cfg_valid / cfg_ready cfg_index, cfg_data
//
// each item makes two passes through the single cordic unit and 17 products on one shared
// multiplier; the yaw wrap steps until the working yaw is in range, and each row waits while
// the output register is held
// the next item is taken while the last row still waits at the output
// reset is synchronous and active low; cfg_ready is always high
`default_nettype none

module orbit_camera_view_matrix_unit #(
    parameter int TRIG_ITERATIONS = 16,
    parameter int FRACTION_BITS   = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_move_dx,
    input  logic signed [15:0] s_move_dy,
    input  logic signed [15:0] s_scroll_step,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_row_index,
    output logic signed [31:0] m_col0,
    output logic signed [31:0] m_col1,
    output logic signed [31:0] m_col2,
    output logic signed [31:0] m_col3,
    output logic               m_last_row,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import ocvm_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    ocvm_ctrl #(
        .TRIG_ITERATIONS(TRIG_ITERATIONS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ocvm_dpath #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_move_dx     (s_move_dx),
        .s_move_dy     (s_move_dy),
        .s_scroll_step (s_scroll_step),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_row_index   (m_row_index),
        .m_col0        (m_col0),
        .m_col1        (m_col1),
        .m_col2        (m_col2),
        .m_col3        (m_col3),
        .m_last_row    (m_last_row)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after an item was taken");

    a_last_row_marks_hom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_row == (m_row_index == ROW_HOM)))
        else $error("last row flag does not match row index");

    a_rows_before_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_row |-> !s_ready)
        else $error("block idle before all rows were sent");
`endif

endmodule

`default_nettype wire

@@ sv/ocvm_ctrl.sv @@
// ocvm_ctrl: sequencer for update, yaw wrap, cordic runs, product schedule and row output
// depends on ocvm_pkg
`default_nettype none

module ocvm_ctrl #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ocvm_pkg::status_t status,
    output ocvm_pkg::cmd_t    cmd
);
    import ocvm_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UPD    = 4'd1;
    localparam logic [3:0] S_WRAP   = 4'd2;
    localparam logic [3:0] S_CLOAD  = 4'd3;
    localparam logic [3:0] S_CSTEP  = 4'd4;
    localparam logic [3:0] S_CSTORE = 4'd5;
    localparam logic [3:0] S_MULA   = 4'd6;
    localparam logic [3:0] S_MULB   = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;

    localparam logic [4:0] ITER_LAST = 5'(TRIG_ITERATIONS - 1);

    logic [3:0] state_reg, state_next;
    logic [4:0] iter_reg, iter_next;
    logic [4:0] mul_reg, mul_next;
    logic [1:0] row_reg, row_next;
    logic       sel_reg, sel_next;

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        mul_next   = mul_reg;
        row_next   = row_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.cor_sel  = sel_reg;
        cmd.cor_iter = iter_reg;
        cmd.mul_idx  = mul_reg;
        cmd.out_row  = row_reg;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_UPD;
                end
            end
            S_UPD: begin
                cmd.update = 1'b1;
                state_next = S_WRAP;
            end
            S_WRAP: begin
                if (status.yaw_in_range) begin
                    cmd.yaw_commit = 1'b1;
                    sel_next       = 1'b0;
                    state_next     = S_CLOAD;
                end else begin
                    cmd.wrap_step = 1'b1;
                end
            end
            S_CLOAD: begin
                cmd.cor_load = 1'b1;
                iter_next    = 5'd0;
                state_next   = S_CSTEP;
            end
            S_CSTEP: begin
                cmd.cor_step = 1'b1;
                if (iter_reg == ITER_LAST) begin
                    state_next = S_CSTORE;
                end else begin
                    iter_next = iter_reg + 5'd1;
                end
            end
            S_CSTORE: begin
                cmd.cor_store = 1'b1;
                if (!sel_reg) begin
                    sel_next   = 1'b1;
                    state_next = S_CLOAD;
                end else begin
                    mul_next   = MUL_RCP;
                    state_next = S_MULA;
                end
            end
            S_MULA: begin
                cmd.mul_issue = 1'b1;
                state_next    = S_MULB;
            end
            S_MULB: begin
                cmd.mul_wb = 1'b1;
                if (mul_reg == MUL_LAST) begin
                    row_next   = ROW_SIDE;
                    state_next = S_EMIT;
                end else begin
                    mul_next   = mul_reg + 5'd1;
                    state_next = S_MULA;
                end
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (row_reg == ROW_HOM) begin
                        state_next = S_IDLE;
                    end else begin
                        row_next = row_reg + 2'd1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            iter_reg  <= 5'd0;
            mul_reg   <= 5'd0;
            row_reg   <= 2'd0;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            mul_reg   <= mul_next;
            row_reg   <= row_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/ocvm_dpath.sv @@
// ocvm_dpath: camera state, target registers, cordic unit, shared multiplier and output register
// depends on ocvm_pkg; driven by ocvm_ctrl commands
`default_nettype none

module ocvm_dpath #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ocvm_pkg::cmd_t      cmd,
    output ocvm_pkg::status_t   status,
    input  logic signed [15:0]  s_move_dx,
    input  logic signed [15:0]  s_move_dy,
    input  logic signed [15:0]  s_scroll_step,
    input  logic                cfg_wr,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                m_ready,
    output logic                m_valid,
    output logic [1:0]          m_row_index,
    output logic signed [31:0]  m_col0,
    output logic signed [31:0]  m_col1,
    output logic signed [31:0]  m_col2,
    output logic signed [31:0]  m_col3,
    output logic                m_last_row
);
    import ocvm_pkg::*;

    localparam int OSH = 30 - FRACTION_BITS;
    localparam longint MIN_RADIUS_L = ((64'sd1 <<< FRACTION_BITS) + 5) / 10;
    localparam logic signed [35:0] MIN_RADIUS = 36'(MIN_RADIUS_L);
    localparam logic signed [35:0] MAX_RADIUS = 36'sd2147483647;
    localparam logic signed [31:0] RADIUS_RESET = 32'(64'sd5 <<< FRACTION_BITS);
    localparam logic signed [31:0] ONE_Q = 32'(64'sd1 <<< FRACTION_BITS);
    localparam logic signed [39:0] COL_HALF = 40'(64'sd1 <<< (OSH - 1));

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] col_fix(input logic signed [33:0] v);
        logic signed [39:0] t;
        t = ($signed({{6{v[33]}}, v}) + COL_HALF) >>> OSH;
        return sat32(t);
    endfunction

    function automatic logic signed [31:0] trans_fix(input logic signed [37:0] d);
        logic signed [39:0] t;
        t = -$signed({{2{d[37]}}, d});
        return sat32(t);
    endfunction

    logic signed [31:0] target_x_reg, target_y_reg, target_z_reg;
    logic signed [15:0] dx_reg, dy_reg, sc_reg;
    logic signed [31:0] yaw_reg, pitch_reg, radius_reg;
    logic signed [35:0] ywrk_reg;
    logic signed [33:0] cor_x_reg, cor_y_reg, cor_z_reg;
    logic               cor_neg_reg;
    logic signed [33:0] cp_reg, sp_reg, cyaw_reg, syaw_reg;
    logic signed [33:0] rcp_reg, ex_reg, ey_reg, ez_reg;
    logic signed [33:0] m10_reg, m12_reg, m20_reg, m22_reg;
    logic signed [37:0] acc_reg, d0_reg, d1_reg, d2_reg;
    logic signed [67:0] prod_reg;
    logic               m_valid_reg;
    logic [1:0]         row_reg;
    logic signed [31:0] col0_reg, col1_reg, col2_reg, col3_reg;

    // state update
    logic signed [41:0] yprod, ytmp, pprod, ptmp, rprod, rtmp;
    logic signed [35:0] yinc, pinc, rinc, psum, rsum, ywrk_next, ycommit;
    logic signed [31:0] pitch_next, radius_next;

    always_comb begin
        yprod = $signed({{26{dx_reg[15]}}, dx_reg}) * SENS_Q32;
        ytmp  = (yprod + 42'sd128) >>> 8;
        yinc  = ytmp[35:0];
        ywrk_next = $signed({{4{yaw_reg[31]}}, yaw_reg}) + yinc + PI_Q28;

        pprod = $signed({{26{dy_reg[15]}}, dy_reg}) * SENS_Q32;
        ptmp  = (pprod + 42'sd128) >>> 8;
        pinc  = ptmp[35:0];
        psum  = $signed({{4{pitch_reg[31]}}, pitch_reg}) + pinc;
        if (psum > PITCH_MAX_Q28) begin
            pitch_next = PITCH_MAX_Q28[31:0];
        end else if (psum < -PITCH_MAX_Q28) begin
            pitch_next = 32'(-PITCH_MAX_Q28);
        end else begin
            pitch_next = psum[31:0];
        end

        rprod = $signed({{26{sc_reg[15]}}, sc_reg}) <<< FRACTION_BITS;
        rtmp  = (rprod + 42'sd256) >>> 9;
        rinc  = rtmp[35:0];
        rsum  = $signed({{4{radius_reg[31]}}, radius_reg}) - rinc;
        if (rsum < MIN_RADIUS) begin
            radius_next = MIN_RADIUS[31:0];
        end else if (rsum > MAX_RADIUS) begin
            radius_next = MAX_RADIUS[31:0];
        end else begin
            radius_next = rsum[31:0];
        end

        ycommit = ywrk_reg - PI_Q28;
    end

    assign status.yaw_in_range = (ywrk_reg >= 36'sd0) && (ywrk_reg < TWO_PI_Q28);
    assign status.out_free     = !m_valid_reg || m_ready;

    // cordic
    logic signed [31:0] cor_ang;
    logic signed [33:0] z0, z_fold, sh_x, sh_y, at;
    logic               neg_fold;

    always_comb begin
        cor_ang = cmd.cor_sel ? yaw_reg : pitch_reg;
        z0 = $signed({cor_ang[31], cor_ang[31], cor_ang}) <<< 2;
        neg_fold = 1'b0;
        z_fold = z0;
        if (z0 > HALF_PI_Q30) begin
            z_fold = z0 - PI_Q30;
            neg_fold = 1'b1;
        end else if (z0 < -HALF_PI_Q30) begin
            z_fold = z0 + PI_Q30;
            neg_fold = 1'b1;
        end
        sh_x = cor_x_reg >>> cmd.cor_iter;
        sh_y = cor_y_reg >>> cmd.cor_iter;
        at   = atan_q30(cmd.cor_iter);
    end

    // shared multiplier
    logic signed [33:0] op_a, op_b, nsy;
    logic signed [67:0] mrnd;
    logic signed [37:0] mres, mneg, acc_sum;

    always_comb begin
        nsy = -syaw_reg;
        op_a = '0;
        op_b = '0;
        case (cmd.mul_idx)
            MUL_RCP: begin op_a = $signed({{2{radius_reg[31]}}, radius_reg}); op_b = cp_reg; end
            MUL_EX:  begin op_a = rcp_reg; op_b = syaw_reg; end
            MUL_EY:  begin op_a = $signed({{2{radius_reg[31]}}, radius_reg}); op_b = sp_reg; end
            MUL_EZ:  begin op_a = rcp_reg; op_b = cyaw_reg; end
            MUL_M10: begin op_a = sp_reg; op_b = syaw_reg; end
            MUL_M12: begin op_a = sp_reg; op_b = cyaw_reg; end
            MUL_M20: begin op_a = cp_reg; op_b = syaw_reg; end
            MUL_M22: begin op_a = cp_reg; op_b = cyaw_reg; end
            MUL_D0A: begin op_a = cyaw_reg; op_b = ex_reg; end
            MUL_D0B: begin op_a = '0; op_b = ey_reg; end
            MUL_D0C: begin op_a = nsy; op_b = ez_reg; end
            MUL_D1A: begin op_a = m10_reg; op_b = ex_reg; end
            MUL_D1B: begin op_a = cp_reg; op_b = ey_reg; end
            MUL_D1C: begin op_a = m12_reg; op_b = ez_reg; end
            MUL_D2A: begin op_a = m20_reg; op_b = ex_reg; end
            MUL_D2B: begin op_a = sp_reg; op_b = ey_reg; end
            MUL_D2C: begin op_a = m22_reg; op_b = ez_reg; end
            default: begin op_a = '0; op_b = '0; end
        endcase
        mrnd    = (prod_reg + (68'sd1 <<< 29)) >>> 30;
        mres    = mrnd[37:0];
        mneg    = -mres;
        acc_sum = acc_reg + mres;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_x_reg <= '0;
            target_y_reg <= '0;
            target_z_reg <= '0;
            yaw_reg      <= '0;
            pitch_reg    <= PITCH_RESET_Q28;
            radius_reg   <= RADIUS_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_index)
                    REG_TARGET_X: target_x_reg <= cfg_data;
                    REG_TARGET_Y: target_y_reg <= cfg_data;
                    REG_TARGET_Z: target_z_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.update) begin
                pitch_reg  <= pitch_next;
                radius_reg <= radius_next;
            end
            if (cmd.yaw_commit) begin
                yaw_reg <= ycommit[31:0];
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            dx_reg <= s_move_dx;
            dy_reg <= s_move_dy;
            sc_reg <= s_scroll_step;
        end
        if (cmd.update) begin
            ywrk_reg <= ywrk_next;
        end else if (cmd.wrap_step) begin
            ywrk_reg <= (ywrk_reg >= 36'sd0) ? ywrk_reg - TWO_PI_Q28 : ywrk_reg + TWO_PI_Q28;
        end
        if (cmd.cor_load) begin
            cor_x_reg   <= CORDIC_GAIN_Q30;
            cor_y_reg   <= '0;
            cor_z_reg   <= z_fold;
            cor_neg_reg <= neg_fold;
        end else if (cmd.cor_step) begin
            if (cor_z_reg >= 34'sd0) begin
                cor_x_reg <= cor_x_reg - sh_y;
                cor_y_reg <= cor_y_reg + sh_x;
                cor_z_reg <= cor_z_reg - at;
            end else begin
                cor_x_reg <= cor_x_reg + sh_y;
                cor_y_reg <= cor_y_reg - sh_x;
                cor_z_reg <= cor_z_reg + at;
            end
        end
        if (cmd.cor_store) begin
            if (cmd.cor_sel) begin
                cyaw_reg <= cor_neg_reg ? -cor_x_reg : cor_x_reg;
                syaw_reg <= cor_neg_reg ? -cor_y_reg : cor_y_reg;
            end else begin
                cp_reg <= cor_neg_reg ? -cor_x_reg : cor_x_reg;
                sp_reg <= cor_neg_reg ? -cor_y_reg : cor_y_reg;
            end
        end
        if (cmd.mul_issue) begin
            prod_reg <= op_a * op_b;
        end
        if (cmd.mul_wb) begin
            case (cmd.mul_idx)
                MUL_RCP: rcp_reg <= mres[33:0];
                MUL_EX:  ex_reg  <= 34'($signed({{6{target_x_reg[31]}}, target_x_reg}) + mres);
                MUL_EY:  ey_reg  <= 34'($signed({{6{target_y_reg[31]}}, target_y_reg}) + mres);
                MUL_EZ:  ez_reg  <= 34'($signed({{6{target_z_reg[31]}}, target_z_reg}) + mres);
                MUL_M10: m10_reg <= mneg[33:0];
                MUL_M12: m12_reg <= mneg[33:0];
                MUL_M20: m20_reg <= mres[33:0];
                MUL_M22: m22_reg <= mres[33:0];
                MUL_D0A, MUL_D1A, MUL_D2A: acc_reg <= mres;
                MUL_D0B, MUL_D1B, MUL_D2B: acc_reg <= acc_sum;
                MUL_D0C: d0_reg <= acc_sum;
                MUL_D1C: d1_reg <= acc_sum;
                MUL_D2C: d2_reg <= acc_sum;
                default: ;
            endcase
        end
        if (cmd.out_load) begin
            row_reg <= cmd.out_row;
            case (cmd.out_row)
                ROW_SIDE: begin
                    col0_reg <= col_fix(cyaw_reg);
                    col1_reg <= '0;
                    col2_reg <= col_fix(nsy);
                    col3_reg <= trans_fix(d0_reg);
                end
                ROW_UP: begin
                    col0_reg <= col_fix(m10_reg);
                    col1_reg <= col_fix(cp_reg);
                    col2_reg <= col_fix(m12_reg);
                    col3_reg <= trans_fix(d1_reg);
                end
                ROW_BACK: begin
                    col0_reg <= col_fix(m20_reg);
                    col1_reg <= col_fix(sp_reg);
                    col2_reg <= col_fix(m22_reg);
                    col3_reg <= trans_fix(d2_reg);
                end
                default: begin
                    col0_reg <= '0;
                    col1_reg <= '0;
                    col2_reg <= '0;
                    col3_reg <= ONE_Q;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_row_index = row_reg;
    assign m_col0      = col0_reg;
    assign m_col1      = col1_reg;
    assign m_col2      = col2_reg;
    assign m_col3      = col3_reg;
    assign m_last_row  = (row_reg == ROW_HOM);

endmodule

`default_nettype wire

@@ tb/sv/tb_orbit_camera_view_matrix_unit.sv @@
// tb_orbit_camera_view_matrix_unit: self-checking testbench, predicts each view matrix row
// from pointer events and target registers; depends on ocvm_pkg and orbit_camera_view_matrix_unit
`default_nettype none

module tb_orbit_camera_view_matrix_unit;
    import ocvm_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int NUM_ITER = 16;
    localparam int FRAC = 16;
    localparam longint MIN_RADIUS = ((64'sd1 <<< FRAC) + 5) / 10;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint ATAN_TAB [0:15] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767};

    typedef struct {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] scroll;
    } event_t;

    typedef struct {
        logic [1:0]         row;
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
        logic signed [31:0] c3;
        logic               last;
    } row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_move_dx = '0;
    logic signed [15:0] s_move_dy = '0;
    logic signed [15:0] s_scroll_step = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_row_index;
    logic signed [31:0] m_col0, m_col1, m_col2, m_col3;
    logic               m_last_row;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    event_t pending_events[$];
    row_t   expected_rows[$];
    int     fail_count = 0;
    int     burst_left = 0;
    int     gap_left = 0;
    int     stall_left = 0;
    bit     hold_req = 1'b0;
    int     hold_left = 0;

    longint tgt_x = 0, tgt_y = 0, tgt_z = 0;
    longint yaw_q28 = 0, pitch_q28 = PITCH_RESET_Q28, radius_q = 64'sd5 <<< FRAC;

    orbit_camera_view_matrix_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_move_dx(s_move_dx), .s_move_dy(s_move_dy), .s_scroll_step(s_scroll_step),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_row_index(m_row_index), .m_col0(m_col0), .m_col1(m_col1),
        .m_col2(m_col2), .m_col3(m_col3), .m_last_row(m_last_row),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic longint round_shift(longint x, int s);
        if (s == 0) return x;
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return round_shift(a * b, 30);
    endfunction

    task automatic angle_trig(input longint a28, output longint c, output longint s);
        longint z, x, y, dx, dy;
        bit neg;
        z = a28 * 4;
        neg = 0;
        if (z > HALF_PI_Q30) begin
            z -= PI_Q30;
            neg = 1;
        end else if (z < -HALF_PI_Q30) begin
            z += PI_Q30;
            neg = 1;
        end
        x = CORDIC_GAIN_Q30;
        y = 0;
        for (int i = 0; i < NUM_ITER; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endtask

    task automatic predict_view_rows(input event_t ev);
        longint y, cp, sp, cy, sy, rcp, ex, ey, ez, d;
        longint m[3][4];
        row_t r;
        y = yaw_q28 + round_shift(longint'(ev.dx) * SENS_Q32, 8) + PI_Q28;
        y = y % TWO_PI_Q28;
        if (y < 0) y += TWO_PI_Q28;
        yaw_q28 = y - PI_Q28;
        pitch_q28 = clamp(pitch_q28 + round_shift(longint'(ev.dy) * SENS_Q32, 8),
                          -PITCH_MAX_Q28, PITCH_MAX_Q28);
        radius_q = clamp(radius_q - round_shift(longint'(ev.scroll) * (64'sd1 <<< FRAC), 9),
                         MIN_RADIUS, S32_MAX);
        angle_trig(pitch_q28, cp, sp);
        angle_trig(yaw_q28, cy, sy);
        rcp = mul_q30(radius_q, cp);
        ex = tgt_x + mul_q30(rcp, sy);
        ey = tgt_y + mul_q30(radius_q, sp);
        ez = tgt_z + mul_q30(rcp, cy);
        m[0][0] = cy;                m[0][1] = 0;  m[0][2] = -sy;
        m[1][0] = -mul_q30(sp, sy);  m[1][1] = cp; m[1][2] = -mul_q30(sp, cy);
        m[2][0] = mul_q30(cp, sy);   m[2][1] = sp; m[2][2] = mul_q30(cp, cy);
        for (int i = 0; i < 3; i++) begin
            d = mul_q30(m[i][0], ex) + mul_q30(m[i][1], ey) + mul_q30(m[i][2], ez);
            r.row = 2'(i);
            r.c0 = 32'(clamp(round_shift(m[i][0], 30 - FRAC), S32_MIN, S32_MAX));
            r.c1 = 32'(clamp(round_shift(m[i][1], 30 - FRAC), S32_MIN, S32_MAX));
            r.c2 = 32'(clamp(round_shift(m[i][2], 30 - FRAC), S32_MIN, S32_MAX));
            r.c3 = 32'(clamp(-d, S32_MIN, S32_MAX));
            r.last = 1'b0;
            expected_rows.push_back(r);
        end
        r.row = ROW_HOM;
        r.c0 = '0; r.c1 = '0; r.c2 = '0;
        r.c3 = 32'(64'sd1 <<< FRAC);
        r.last = 1'b1;
        expected_rows.push_back(r);
    endtask

    // target registers mirror
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TARGET_X: tgt_x = longint'($signed(cfg_data));
                REG_TARGET_Y: tgt_y = longint'($signed(cfg_data));
                REG_TARGET_Z: tgt_z = longint'($signed(cfg_data));
                default: ;
            endcase
        end
    end

    // event driver
    always @(posedge aclk) begin
        event_t ev;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                ev.dx = s_move_dx;
                ev.dy = s_move_dy;
                ev.scroll = s_scroll_step;
                predict_view_rows(ev);
            end
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_events.size() > 0) begin
                ev = pending_events.pop_front();
                s_move_dx <= ev.dx;
                s_move_dy <= ev.dy;
                s_scroll_step <= ev.scroll;
                s_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // row receiver and checker
    always @(posedge aclk) begin
        row_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rows.size() == 0) begin
                $display("%0t: unexpected row %0d", $time, m_row_index);
                fail_count++;
            end else begin
                e = expected_rows.pop_front();
                if (m_row_index !== e.row || m_col0 !== e.c0 || m_col1 !== e.c1 ||
                    m_col2 !== e.c2 || m_col3 !== e.c3 || m_last_row !== e.last) begin
                    $display("%0t: expected row %0d %0d %0d %0d %0d last %0d", $time,
                             e.row, e.c0, e.c1, e.c2, e.c3, e.last);
                    $display("%0t: actual   row %0d %0d %0d %0d %0d last %0d", $time,
                             m_row_index, m_col0, m_col1, m_col2, m_col3, m_last_row);
                    fail_count++;
                end
            end
        end
        if (hold_req && hold_left == 0) begin
            hold_req = 1'b0;
            hold_left = 700;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 40);
        end
    end

    function automatic event_t random_event(bit grow);
        event_t ev;
        if ($urandom_range(0, 9) < 7) begin
            ev.dx = 16'($signed($urandom_range(0, 400)) - 200);
            ev.dy = 16'($signed($urandom_range(0, 400)) - 200);
            ev.scroll = 16'($signed($urandom_range(0, 512)) - 256);
        end else begin
            ev.dx = 16'($urandom);
            ev.dy = 16'($urandom);
            ev.scroll = 16'($urandom);
        end
        if (grow) ev.scroll = 16'sh8000 + 16'($urandom_range(0, 15));
        return ev;
    endfunction

    task automatic add_event(logic signed [15:0] dx, logic signed [15:0] dy,
                             logic signed [15:0] sc);
        event_t ev;
        ev.dx = dx;
        ev.dy = dy;
        ev.scroll = sc;
        pending_events.push_back(ev);
    endtask

    task automatic write_targets(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        logic [1:0]  idx [4];
        logic [31:0] val [4];
        idx = '{REG_TARGET_X, REG_TARGET_Y, REG_TARGET_Z, REG_UNUSED};
        val = '{x, y, z, $urandom};
        for (int i = 0; i < 4; i++) begin
            cfg_index <= idx[i];
            cfg_data <= val[i];
            cfg_valid <= 1'b1;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (pending_events.size() > 0 || s_valid || expected_rows.size() > 0)
            @(negedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes, clamps, floor, yaw wrap
        add_event(16'sd0, 16'sd0, 16'sd0);
        add_event(16'sh7fff, 16'sd0, 16'sd0);
        add_event(16'sh8000, 16'sd0, 16'sd0);
        add_event(16'sh7fff, 16'sd0, 16'sd0);
        add_event(16'sh7fff, 16'sd0, 16'sd0);
        add_event(16'sd0, 16'sh7fff, 16'sd0);
        add_event(16'sd0, 16'sh7fff, 16'sd0);
        add_event(16'sd0, 16'sh8000, 16'sd0);
        add_event(16'sd0, 16'sh8000, 16'sd0);
        add_event(16'sd0, 16'sd0, 16'sh7fff);
        add_event(16'sd0, 16'sd0, 16'sh7fff);
        add_event(16'sd0, 16'sd0, 16'sh8000);
        add_event(16'shffff, 16'shffff, 16'shffff);
        add_event(16'sd1, 16'sd1, 16'sd1);
        add_event(16'sh5555, 16'sh2aaa, 16'sh8000);
        add_event(16'sh2aaa, 16'sh5555, 16'sh00ff);
        add_event(16'sh8000, 16'sh7fff, 16'sh8000);
        add_event(16'sd628, -16'sd40, -16'sd2);
        add_event(-16'sd628, 16'sd40, 16'sd2);
        add_event(16'sh8000, 16'sh8000, 16'sh7fff);
        wait_idle();

        write_targets(32'h7fffffff, 32'h80000000, 32'h00000000);
        hold_req = 1'b1;
        repeat (40) pending_events.push_back(random_event(0));
        wait_idle();

        write_targets($urandom, $urandom, $urandom);
        repeat (380) pending_events.push_back(random_event(1));
        wait_idle();

        write_targets(32'h80000000, 32'h7fffffff, 32'h80000000);
        repeat (40) pending_events.push_back(random_event(0));
        wait_idle();

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(12 * 3_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
